>>> src/mbd_pkg.sv
package mbd_pkg;

	localparam int MaxWidth  = 2048;
	localparam int MaxLevels = 12;
	localparam int LvlW      = 4;
	localparam int CrdW      = 11;
	localparam int AddrW     = 11;
	localparam int CfgW      = 12;

	// register indexes
	localparam logic [1:0] RegWidth  = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;
	localparam logic [1:0] RegLevels = 2'd2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_in_t;

	typedef struct packed {
		logic [LvlW-1:0] level;
		logic [CrdW-1:0] column;
		logic [CrdW-1:0] row;
		logic [7:0]      out_red;
		logic [7:0]      out_green;
		logic [7:0]      out_blue;
		logic [7:0]      out_alpha;
		logic            last_of_run;
	} pix_out_t;

endpackage

>>> src/mbd_line_ram.sv
module mbd_line_ram (
	input  logic                     clk,
	input  logic                     we,
	input  logic [mbd_pkg::AddrW-1:0] waddr,
	input  logic [35:0]              wdata,
	input  logic [mbd_pkg::AddrW-1:0] raddr,
	output logic [35:0]              rdata
);
	import mbd_pkg::*;

	logic [35:0] mem [MaxWidth];

	// one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/mipmap_box_downsample_unit.sv
// Mip chain generator: RGBA8 level zero pixels enter on the in channel in
// raster order; every pixel of every level leaves on the out channel with
// its level and coordinates. Level k+1 pixels are the truncated mean of a
// 2x2 block of level k pixels.
// Each request yields one result per level it completes, level zero first,
// last_of_run marking the final one. The first result is registered
// once the request has put the block in ST_EMIT and the output register
// is free or emptying. In ST_EMIT each level's pixel is emitted while the
// line store is read or written; ST_READ forms the next level's mean.
// Results go through a single output register; a new request is taken in
// the cycle its predecessor's final result is registered, so a stalled
// receiver only holds the block until that register empties.
// Reset clears counters and hold registers and sets the size registers to
// 2048 x 2048 with 12 levels. The line store needs no clearing pass.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, as the block does not enforce it.
module mipmap_box_downsample_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [11:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  mbd_pkg::pix_in_t        in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output mbd_pkg::pix_out_t       out_data
);
	import mbd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EMIT = 3'b010,
		ST_READ = 3'b100
	} state_t;

	logic [11:0] width_q, height_q;
	logic [3:0]  levels_q;

	state_t      state_q;
	logic [35:0] pix_q;
	logic [3:0]  k_q;
	logic [11:0] w_q, h_q;
	logic [11:0] base_q;
	logic [3:0]  llv_q;

	logic [35:0] hold_q [MaxLevels];
	logic [10:0] col_q  [MaxLevels];
	logic [10:0] row_q  [MaxLevels];

	pix_out_t out_q;
	logic     ovalid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd2048;
			height_q <= 12'd2048;
			levels_q <= 4'd12;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegWidth:  width_q  <= cfg_data;
				RegHeight: height_q <= cfg_data;
				RegLevels: levels_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp sizes
	logic [11:0] wc, hc;
	logic [3:0]  lvc;
	assign wc  = (width_q  > 12'd2048) ? 12'd2048 : width_q;
	assign hc  = (height_q > 12'd2048) ? 12'd2048 : height_q;
	assign lvc = (levels_q > 4'd12) ? 4'd12 : levels_q;

	// current level view
	logic [10:0] x, y;
	logic [11:0] wn, hn, x12, y12;
	logic        oslot_free;
	assign x   = col_q[k_q];
	assign y   = row_q[k_q];
	assign x12 = {1'b0, x};
	assign y12 = {1'b0, y};
	assign wn  = {1'b0, w_q[11:1]};
	assign hn  = {1'b0, h_q[11:1]};
	assign oslot_free = !ovalid_q || out_ready;

	logic        go_on, pair_even, idx_ok;
	logic [11:0] idx;
	assign idx      = base_q + {2'b0, x[10:1]};
	assign idx_ok   = idx < 12'd2048;
	assign go_on    = ({1'b0, k_q} + 5'd1 < {1'b0, llv_q}) && wn != 12'd0 && hn != 12'd0
		&& x12 < {wn[10:0], 1'b0} && y12 < {hn[10:0], 1'b0} && x[0] && idx_ok;
	assign pair_even = !y[0];

	// pair sum of held and current pixel
	logic [35:0] pair;
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			pair[9*c +: 9] = hold_q[k_q][9*c +: 9] + pix_q[9*c +: 9];
		end
	end

	// line store
	logic        ram_we;
	logic [35:0] ram_rd;
	assign ram_we = (state_q == ST_EMIT) && oslot_free && go_on && pair_even;
	mbd_line_ram u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx[10:0]),
		.wdata(pair),
		.raddr(idx[10:0]),
		.rdata(ram_rd)
	);

	// four-pixel mean
	logic [35:0] mean;
	always_comb begin
		logic [9:0] s;
		for (int c = 0; c < 4; c++) begin
			s = {1'b0, ram_rd[9*c +: 9]} + {1'b0, pair[9*c +: 9]};
			mean[9*c +: 9] = {1'b0, s[9:2]};
		end
	end

	logic emit_fire, emit_last, start;
	assign emit_fire = (state_q == ST_EMIT) && oslot_free;
	assign emit_last = !(go_on && !pair_even);
	assign start     = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE)
		|| (emit_fire && emit_last);

	logic lvl_ok;
	assign lvl_ok = wc != 12'd0 && hc != 12'd0 && lvc != 4'd0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < MaxLevels; i++) begin
				hold_q[i] <= '0;
				col_q[i]  <= '0;
				row_q[i]  <= '0;
			end
		end else begin
			if (emit_fire) begin
				// advance counters of this level
				if (x12 + 12'd1 >= w_q) begin
					col_q[k_q] <= '0;
					row_q[k_q] <= (y12 + 12'd1 >= h_q) ? 11'd0 : y + 11'd1;
				end else begin
					col_q[k_q] <= x + 11'd1;
				end
				if ((({1'b0, k_q} + 5'd1 < {1'b0, llv_q}) && wn != 12'd0 && hn != 12'd0
					&& x12 < {wn[10:0], 1'b0} && y12 < {hn[10:0], 1'b0} && !x[0])) begin
					hold_q[k_q] <= pix_q;
				end
			end
			priority if (start) begin
				state_q <= lvl_ok ? ST_EMIT : ST_IDLE;
			end else if (emit_fire) begin
				state_q <= emit_last ? ST_IDLE : ST_READ;
			end else if (state_q == ST_READ) begin
				state_q <= ST_EMIT;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			pix_q  <= {1'b0, in_data.alpha, 1'b0, in_data.blue,
				1'b0, in_data.green, 1'b0, in_data.red};
			k_q    <= '0;
			w_q    <= wc;
			h_q    <= hc;
			base_q <= '0;
			llv_q  <= lvc;
		end else if (state_q == ST_READ) begin
			pix_q  <= mean;
			k_q    <= k_q + 4'd1;
			base_q <= base_q + wn;
			w_q    <= wn;
			h_q    <= hn;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_fire) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_q.level       <= k_q;
			out_q.column      <= x;
			out_q.row         <= y;
			out_q.out_red     <= pix_q[7:0];
			out_q.out_green   <= pix_q[16:9];
			out_q.out_blue    <= pix_q[25:18];
			out_q.out_alpha   <= pix_q[34:27];
			out_q.last_of_run <= emit_last;
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = out_q;
endmodule

>>> src/mbd_checker.sv
module mbd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input mbd_pkg::pix_out_t out_data
);
	import mbd_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");

	// levels stay in range
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.level < 4'(MaxLevels))
		else $error("level out of range");

	// a non-final result is followed by the next level
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_of_run ##1 out_valid |->
		out_data.level != 4'd0)
		else $error("run broken");

	// no new request while a stalled run is unfinished
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !out_data.last_of_run |-> !in_ready)
		else $error("request taken mid-run");

	// shown results are fully defined
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_data))
		else $error("unknown result");
endmodule

bind mipmap_box_downsample_unit mbd_checker u_mbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

>>> verif/mipmap_box_downsample_unit_tb.sv
module mipmap_box_downsample_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mbd_pkg::*;

	localparam int IdleLimit = 20000;

	// expected-pixel store and mismatch bookkeeping
	class mip_scoreboard;
		pix_out_t pending_pixels[$];
		int mismatches = 0;
		int shown = 0;

		function void note_request(pix_out_t res[$]);
			foreach (res[i]) pending_pixels.push_back(res[i]);
		endfunction

		function void check_pixel(pix_out_t got);
			pix_out_t want;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (shown < 10) begin
					shown++;
					$display("unexpected pixel %p", got);
				end
				return;
			end
			want = pending_pixels.pop_front();
			if (got !== want) begin
				mismatches++;
				if (shown < 10) begin
					shown++;
					$display("pixel mismatch: expected %p got %p", want, got);
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = RegWidth;
	logic [11:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	pix_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	pix_out_t out_data;

	mipmap_box_downsample_unit dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	mip_scoreboard sb = new();

	// predictor state
	logic [11:0] width_reg = 12'd2048, height_reg = 12'd2048;
	logic [3:0] levels_reg = 4'd12;
	logic [35:0] pair_store[MaxWidth];
	logic [35:0] hold_pair[MaxLevels];
	int unsigned col_cnt[MaxLevels], row_cnt[MaxLevels];
	int idle_cycles = 0;

	initial begin
		foreach (hold_pair[i]) begin
			hold_pair[i] = '0;
			col_cnt[i] = 0;
			row_cnt[i] = 0;
		end
		foreach (pair_store[i]) pair_store[i] = '0;
	end

	// compute every mip pixel that one source pixel completes
	function automatic void predict_mip_pixels(pix_in_t px, ref pix_out_t res[$]);
		int unsigned w, h, lv, base, k, x, y, wn, hn, idx, s;
		logic [35:0] pix, pair, sum;
		pix_out_t r;
		w = width_reg > MaxWidth ? MaxWidth : width_reg;
		h = height_reg > MaxWidth ? MaxWidth : height_reg;
		lv = levels_reg > MaxLevels ? MaxLevels : levels_reg;
		base = 0;
		k = 0;
		res = {};
		if (w == 0 || h == 0 || lv == 0) return;
		pix = {1'b0, px.alpha, 1'b0, px.blue, 1'b0, px.green, 1'b0, px.red};
		forever begin
			x = col_cnt[k];
			y = row_cnt[k];
			wn = w >> 1;
			hn = h >> 1;
			r.level = k[3:0];
			r.column = x[10:0];
			r.row = y[10:0];
			r.out_red = pix[7:0];
			r.out_green = pix[16:9];
			r.out_blue = pix[25:18];
			r.out_alpha = pix[34:27];
			r.last_of_run = 0;
			res.push_back(r);
			if (x + 1 >= w) begin
				col_cnt[k] = 0;
				row_cnt[k] = (y + 1 >= h) ? 0 : y + 1;
			end else col_cnt[k] = x + 1;
			if (k + 1 >= lv || wn == 0 || hn == 0) break;
			if (x >= 2 * wn || y >= 2 * hn) break;
			if (x[0] == 0) begin
				hold_pair[k] = pix;
				break;
			end
			for (int c = 0; c < 4; c++)
				pair[9*c +: 9] = hold_pair[k][9*c +: 9] + pix[9*c +: 9];
			idx = base + (x >> 1);
			if (idx >= MaxWidth) break;
			if (y[0] == 0) begin
				pair_store[idx] = pair;
				break;
			end
			for (int c = 0; c < 4; c++) begin
				s = pair_store[idx][9*c +: 9] + pair[9*c +: 9];
				sum[9*c +: 9] = 9'(s >> 2);
			end
			pix = sum;
			base += wn;
			w = wn;
			h = hn;
			k++;
		end
		res[res.size()-1].last_of_run = 1;
	endfunction

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// send one source pixel and note what it should produce
	task automatic send_pixel(pix_in_t px);
		pix_out_t res[$];
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_data <= px;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		predict_mip_pixels(px, res);
		sb.note_request(res);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [11:0] val);
		in_valid <= 0;
		while (sb.pending_pixels.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			RegWidth: width_reg = val;
			RegHeight: height_reg = val;
			default: levels_reg = val[3:0];
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic pix_in_t rand_pixel();
		pix_in_t p;
		p = $urandom;
		return p;
	endfunction

	// one full frame at the given size
	task automatic run_frame(int w, int h, int lv, bit directed);
		pix_in_t p;
		write_reg(RegWidth, 12'(w));
		write_reg(RegHeight, 12'(h));
		write_reg(RegLevels, 12'(lv));
		for (int i = 0; i < w * h; i++) begin
			if (directed) case (i % 4)
				0: p = '0;
				1: p = '1;
				2: p = 32'hAA55_F00F;
				default: p = 32'h55AA_0FF0;
			endcase
			else p = rand_pixel();
			send_pixel(p);
		end
	endtask

	// receiver with random stalls
	always @(negedge clk) begin
		if (arst_n) out_ready <= ($urandom_range(0, 9) < 2) ? 0 :
			(pick_gap() == 0 || $urandom_range(0, 1));
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_pixel(out_data);
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: extremes, odd sizes, single level, degenerate widths
		run_frame(4, 4, 3, 1);
		run_frame(3, 3, 2, 1);
		run_frame(1, 2, 12, 1);
		run_frame(2, 1, 1, 1);
		// random frames; oversized registers saturate
		run_frame(8, 4, 15, 0);
		run_frame(5, 7, 4, 0);
		run_frame(16, 2, 12, 0);
		run_frame(6, 6, 0, 0);
		run_frame(4, 8, 3, 0);
		run_frame(7, 2, 2, 0);
		write_reg(RegWidth, 12'hFFF);
		write_reg(RegHeight, 12'hFFF);
		write_reg(RegLevels, 12'd12);
		for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
		in_valid <= 0;
		while (sb.pending_pixels.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
